// ===== rtl/fpba_pkg.sv =====
// ----------------------------------------------------------------------------
// fpba_pkg: shared types and codes for the fit-policy block allocator
// Word layouts of the item and result channels, status, kind, policy and
// register index codes.
// ----------------------------------------------------------------------------
package fpba_pkg;

	localparam int BLK_W  = 4;
	localparam int FLD_W  = 16;
	localparam int CFG_W  = 5;
	localparam int CIDX_W = 1;

	localparam logic KIND_LOAD    = 1'b0;
	localparam logic KIND_REQUEST = 1'b1;

	localparam logic [1:0] ST_LOADED = 2'd0;
	localparam logic [1:0] ST_ALLOC  = 2'd1;
	localparam logic [1:0] ST_NONE   = 2'd2;

	localparam logic [1:0] POL_FIRST = 2'd0;
	localparam logic [1:0] POL_BEST  = 2'd1;
	localparam logic [1:0] POL_WORST = 2'd2;

	localparam logic [CIDX_W-1:0] CFG_FIT_POLICY    = 1'b0;
	localparam logic [CIDX_W-1:0] CFG_BLOCKS_IN_USE = 1'b1;

	localparam logic [CFG_W-1:0] BLOCKS_RESET = 5'd16;

	typedef struct packed {
		logic             kind;
		logic [BLK_W-1:0] block_index;
		logic [FLD_W-1:0] block_capacity;
		logic [FLD_W-1:0] request_size;
	} item_word_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [BLK_W-1:0] chosen_block;
		logic [FLD_W-1:0] remaining_size;
	} result_word_t;

endpackage

// ===== rtl/fit_policy_block_allocator_top.sv =====
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_top: first, best and worst fit block allocator
// Keeps a table of free block sizes; loads write one entry, requests scan
// the blocks in use one per cycle and carve the size from the chosen block.
// ----------------------------------------------------------------------------
// Load word: accept moves to S_DONE, which registers the result word.
// Request word: accept moves through S_SCAN, S_UPDATE and S_DONE; S_SCAN reads
// min(blocks_in_use, NUM_BLOCKS) table entries, one table read per cycle.
// One word in flight at a time; the next word is taken once the result is
// registered, even while that result is stalled.
// Reset sets fit_policy 0, blocks_in_use 16; the size table is not cleared.
module fit_policy_block_allocator_top #(
	parameter int NUM_BLOCKS = 16,
	parameter int SIZE_BITS  = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_stall,
	input  fpba_pkg::item_word_t        item,
	output logic                        result_valid,
	input  logic                        result_stall,
	output fpba_pkg::result_word_t      result,
	input  logic                        cfg_we,
	input  logic [fpba_pkg::CIDX_W-1:0] cfg_index,
	input  logic [fpba_pkg::CFG_W-1:0]  cfg_data
);
	import fpba_pkg::*;

	localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_UPDATE, S_DONE} state_t;

	state_t                 state_q;
	logic [1:0]             policy_q;
	logic [CFG_W-1:0]       blocks_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [CNT_W-1:0]       lim_q;
	logic                   rd_vld_s1;
	logic [IDX_W-1:0]       rd_idx_s1;
	logic [SIZE_BITS-1:0]   rd_data_s1;
	logic                   found_q;
	logic [IDX_W-1:0]       best_idx_q;
	logic [SIZE_BITS-1:0]   best_size_q;
	logic [SIZE_BITS-1:0]   need_q;
	result_word_t           res_q;
	logic                   result_valid_q;
	result_word_t           result_q;

	logic [SIZE_BITS-1:0]   mem [NUM_BLOCKS];

	logic                   accept;
	logic                   load_hit;
	logic                   mem_we;
	logic [IDX_W-1:0]       mem_waddr;
	logic [SIZE_BITS-1:0]   mem_wdata;
	logic [SIZE_BITS-1:0]   left;
	logic [CNT_W-1:0]       lim;
	logic                   fits;
	logic                   take;

	assign item_stall   = (state_q != S_IDLE);
	assign accept       = item_valid && (state_q == S_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign load_hit = accept && (item.kind == KIND_LOAD)
		&& (32'(item.block_index) < 32'(NUM_BLOCKS));
	assign left     = best_size_q - need_q;
	assign lim      = (32'(blocks_q) > 32'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS)
		: CNT_W'(blocks_q);

	assign mem_we    = load_hit || ((state_q == S_UPDATE) && found_q);
	assign mem_waddr = load_hit ? IDX_W'(item.block_index) : best_idx_q;
	assign mem_wdata = load_hit ? SIZE_BITS'(item.block_capacity) : left;

	assign fits = (rd_data_s1 >= need_q);
	assign take = rd_vld_s1 && fits && (!found_q
		|| ((policy_q == POL_BEST) && (rd_data_s1 < best_size_q))
		|| ((policy_q == POL_WORST) && (rd_data_s1 > best_size_q)));

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_data_s1 <= mem[cnt_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			policy_q       <= POL_FIRST;
			blocks_q       <= BLOCKS_RESET;
			cnt_q          <= '0;
			lim_q          <= '0;
			rd_vld_s1      <= 1'b0;
			rd_idx_s1      <= '0;
			found_q        <= 1'b0;
			best_idx_q     <= '0;
			best_size_q    <= '0;
			need_q         <= '0;
			res_q          <= '0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_FIT_POLICY:    policy_q <= cfg_data[1:0];
					CFG_BLOCKS_IN_USE: blocks_q <= cfg_data;
					default:           ;
				endcase
			end

			if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end

			rd_vld_s1 <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (item.kind == KIND_LOAD) begin
							res_q   <= '{status: ST_LOADED, default: '0};
							state_q <= S_DONE;
						end else begin
							need_q  <= SIZE_BITS'(item.request_size);
							lim_q   <= lim;
							cnt_q   <= '0;
							found_q <= 1'b0;
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (cnt_q < lim_q) begin
						cnt_q     <= cnt_q + 1'b1;
						rd_vld_s1 <= 1'b1;
						rd_idx_s1 <= cnt_q[IDX_W-1:0];
					end
					if (take) begin
						found_q     <= 1'b1;
						best_idx_q  <= rd_idx_s1;
						best_size_q <= rd_data_s1;
					end
					if ((cnt_q == lim_q) && !rd_vld_s1) begin
						state_q <= S_UPDATE;
					end
				end
				S_UPDATE: begin
					if (found_q) begin
						res_q.status         <= ST_ALLOC;
						res_q.chosen_block   <= BLK_W'(best_idx_q);
						res_q.remaining_size <= FLD_W'(left);
					end else begin
						res_q <= '{status: ST_NONE, default: '0};
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!result_valid_q || !result_stall) begin
						result_valid_q <= 1'b1;
						result_q       <= res_q;
						state_q        <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/fpba_checker.sv =====
// ----------------------------------------------------------------------------
// fpba_checker: port-level checks for the fit-policy block allocator
// Watches the item and result channels of the top level over time.
// ----------------------------------------------------------------------------
module fpba_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        item_valid,
	input logic                        item_stall,
	input logic                        result_valid,
	input logic                        result_stall,
	input fpba_pkg::result_word_t      result
);
	import fpba_pkg::*;

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result word changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("item taken while previous word in flight");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status == ST_NONE)
		|-> (result.chosen_block == '0) && (result.remaining_size == '0))
		else $error("unallocated result carries block data");

	a_loaded_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status == ST_LOADED)
		|-> (result.chosen_block == '0) && (result.remaining_size == '0))
		else $error("load result carries block data");

endmodule

bind fit_policy_block_allocator_top fpba_checker u_fpba_checker (.*);

// ===== tb/sv/fit_policy_block_allocator_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_top_tb: allocator placement and table check
// Loads the size table, then drives directed and random load and request
// words under every fit policy and several scan widths. A local model of
// the table predicts each result word, and random gaps and stalls are
// applied on both channels.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator_top_tb;
	import fpba_pkg::*;

	localparam int          NBLK          = 16;
	localparam logic [1:0]  POL_UNUSED    = 2'd3;
	localparam int          PHASES        = 10;
	localparam int          PHASE_WORDS   = 108;
	localparam int          SETTLE_CYCLES = 2 * NBLK + 8;
	localparam int          MAX_PRINTS    = 60;
	localparam longint      TIMEOUT_NS    = 5_000_000;

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                item_valid   = 1'b0;
	logic                item_stall;
	item_word_t          item         = '0;
	logic                result_valid;
	logic                result_stall = 1'b0;
	result_word_t        result;
	logic                cfg_we       = 1'b0;
	logic [CIDX_W-1:0]   cfg_index    = '0;
	logic [CFG_W-1:0]    cfg_data     = '0;

	logic [FLD_W-1:0]    free_size_tbl [NBLK];
	logic [1:0]          fit_sel      = POL_FIRST;
	logic [CFG_W-1:0]    blocks_used  = BLOCKS_RESET;
	result_word_t        pending_results [$];
	result_word_t        due_word;
	int                  err_count    = 0;
	int                  stall_left   = 0;
	bit                  no_idle      = 1'b0;

	fit_policy_block_allocator_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #4 clk = ~clk;

	function automatic int draw_wait();
		if (no_idle)
			return 0;
		return $urandom_range(0, 12);
	endfunction

	function automatic result_word_t allocate_model(item_word_t w);
		result_word_t r;
		int           lim;
		int           j;
		int           pick;
		bit           found;
		r        = '0;
		r.status = ST_LOADED;
		if (w.kind == KIND_LOAD) begin
			free_size_tbl[w.block_index] = w.block_capacity;
			return r;
		end
		lim   = (blocks_used > NBLK) ? NBLK : int'(blocks_used);
		found = 1'b0;
		pick  = 0;
		for (j = 0; j < lim; j++) begin
			if (free_size_tbl[j] >= w.request_size) begin
				if (!found) begin
					found = 1'b1;
					pick  = j;
					if (fit_sel != POL_BEST && fit_sel != POL_WORST)
						break;
				end else if (fit_sel == POL_BEST && free_size_tbl[j] < free_size_tbl[pick]) begin
					pick = j;
				end else if (fit_sel == POL_WORST && free_size_tbl[j] > free_size_tbl[pick]) begin
					pick = j;
				end
			end
		end
		if (found) begin
			free_size_tbl[pick] = free_size_tbl[pick] - w.request_size;
			r.status            = ST_ALLOC;
			r.chosen_block      = pick[BLK_W-1:0];
			r.remaining_size    = free_size_tbl[pick];
		end else begin
			r.status = ST_NONE;
		end
		return r;
	endfunction

	function automatic item_word_t random_word();
		item_word_t       w;
		logic [FLD_W-1:0] base;
		w.kind           = ($urandom_range(0, 2) == 0) ? KIND_LOAD : KIND_REQUEST;
		w.block_index    = BLK_W'($urandom_range(0, NBLK - 1));
		w.block_capacity = FLD_W'($urandom);
		w.request_size   = FLD_W'($urandom);
		if (w.kind == KIND_LOAD) begin
			case ($urandom_range(0, 5))
				0: w.block_capacity = '0;
				1: w.block_capacity = '1;
				2: w.block_capacity = FLD_W'($urandom_range(0, 255));
				default: ;
			endcase
		end else begin
			base = free_size_tbl[BLK_W'($urandom_range(0, NBLK - 1))];
			case ($urandom_range(0, 9))
				0: w.request_size = '0;
				1: ;
				2: w.request_size = base;
				3: w.request_size = base + 1'b1;
				default: w.request_size = FLD_W'($urandom_range(0, base));
			endcase
		end
		return w;
	endfunction

	task automatic report_mismatch(string msg);
		if (err_count < MAX_PRINTS)
			$display("[%0t] mismatch: %s", $realtime, msg);
		err_count++;
	endtask

	task automatic send_word(item_word_t w);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item       <= w;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		pending_results.push_back(allocate_model(w));
	endtask

	task automatic settle();
		item_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_FIT_POLICY)
			fit_sel = val[1:0];
		else
			blocks_used = val;
		@(posedge clk);
	endtask

	task automatic send_request(logic [FLD_W-1:0] size);
		item_word_t w;
		w              = '0;
		w.kind         = KIND_REQUEST;
		w.request_size = size;
		send_word(w);
	endtask

	task automatic test_load_first_fit();
		logic [FLD_W-1:0] caps [NBLK];
		item_word_t       w;
		int               i;
		caps = '{16'd0, 16'd40, 16'd900, 16'd100, 16'd3000, 16'd65535, 16'd250, 16'd100,
			16'd7, 16'd12000, 16'd65535, 16'd512, 16'd64, 16'd33333, 16'd1, 16'd65535};
		for (i = 0; i < NBLK; i++) begin
			w                = '0;
			w.kind           = KIND_LOAD;
			w.block_index    = i[BLK_W-1:0];
			w.block_capacity = caps[i];
			send_word(w);
		end
		send_request(16'd0);
		send_request(16'hFFFF);
		send_request(16'd100);
		settle();
	endtask

	task automatic test_policy_cases();
		write_reg(CFG_FIT_POLICY, {3'b000, POL_BEST});
		send_request(16'd100);
		settle();
		write_reg(CFG_FIT_POLICY, {3'b000, POL_WORST});
		send_request(16'd10);
		settle();
		write_reg(CFG_FIT_POLICY, {3'b000, POL_UNUSED});
		send_request(16'd50);
		settle();
		write_reg(CFG_BLOCKS_IN_USE, 5'd0);
		send_request(16'd0);
		settle();
		write_reg(CFG_BLOCKS_IN_USE, 5'd31);
		write_reg(CFG_FIT_POLICY, {3'b000, POL_WORST});
		send_request(16'd60000);
		settle();
		write_reg(CFG_BLOCKS_IN_USE, 5'd1);
		send_request(16'hFFFF);
		settle();
	endtask

	task automatic test_random_phases();
		logic [1:0]       pols [PHASES];
		logic [CFG_W-1:0] widths [PHASES];
		int               p;
		int               n;
		pols   = '{POL_FIRST, POL_BEST, POL_WORST, POL_UNUSED, POL_BEST,
			POL_WORST, POL_FIRST, POL_BEST, POL_WORST, POL_FIRST};
		widths = '{5'd16, 5'd1, 5'd16, 5'd5, 5'd31, 5'd0, 5'd8, 5'd17, 5'd16, 5'd16};
		pols[PHASES-1]   = 2'($urandom_range(0, 3));
		widths[PHASES-1] = CFG_W'($urandom_range(1, NBLK));
		for (p = 0; p < PHASES; p++) begin
			settle();
			write_reg(CFG_FIT_POLICY, {3'b000, pols[p]});
			write_reg(CFG_BLOCKS_IN_USE, widths[p]);
			no_idle = ($urandom_range(0, 3) == 0);
			for (n = 0; n < PHASE_WORDS; n++) begin
				if (n == PHASE_WORDS / 2) begin
					no_idle = !no_idle;
					if (p == 3)
						settle();
				end
				send_word(random_word());
			end
		end
		no_idle = 1'b0;
		settle();
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (pending_results.size() == 0) begin
					report_mismatch("result word with nothing expected");
				end else begin
					due_word = pending_results.pop_front();
					if (result.status !== due_word.status)
						report_mismatch($sformatf("status %0d, expected %0d",
							result.status, due_word.status));
					if (result.chosen_block !== due_word.chosen_block)
						report_mismatch($sformatf("chosen_block %0d, expected %0d",
							result.chosen_block, due_word.chosen_block));
					if (result.remaining_size !== due_word.remaining_size)
						report_mismatch($sformatf("remaining_size %0d, expected %0d",
							result.remaining_size, due_word.remaining_size));
				end
				stall_left = draw_wait();
				result_stall <= (stall_left != 0);
			end else if (stall_left != 0) begin
				stall_left--;
				result_stall <= (stall_left != 0);
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_load_first_fit();
		test_policy_cases();
		test_random_phases();
		if (err_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("FAILURE");
		$finish;
	end

endmodule

// ===== fit_policy_block_allocator_top.f =====
rtl/fpba_pkg.sv
rtl/fit_policy_block_allocator_top.sv
rtl/fpba_checker.sv
tb/sv/fit_policy_block_allocator_top_tb.sv
